// File: rtl/lud_pkg.sv
// Shared types, constants and helpers for the lens point undistortion unit.
`timescale 1ns / 1ps
`default_nettype none

package lud_pkg;

   // internal datapath word: signed Q.28 held in 48 bits
   localparam int WORD_W      = 48;
   localparam int SUM_W       = WORD_W + 4;
   localparam int FRAC_BITS   = 28;
   localparam int FRONT_SHIFT = 20;
   localparam int COEF_PAD    = 4;
   localparam int IN_W        = 32;
   localparam int OUT_W       = 32;

   localparam int ITERATIONS_DEF = 5;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [OUT_W-1:0]  out_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam word_type ONE_Q28  = word_type'(1) <<< FRAC_BITS;

   // reciprocal: 2^RECIP_NUM_SHIFT / den, quotient below 2^(WORD_W-1)
   localparam int RECIP_NUM_SHIFT = 56;
   localparam int Q_BITS          = WORD_W - 1;
   localparam logic [WORD_W-1:0] REM_INIT =
      {{(WORD_W-1){1'b0}}, 1'b1} << (RECIP_NUM_SHIFT - Q_BITS);

   // pipeline timing, in register stages
   localparam int MUL_LAT   = 5;
   localparam int RECIP_LAT = Q_BITS + 2;
   localparam int FRONT_LAT = 1 + MUL_LAT;
   localparam int R2_T      = MUL_LAT + 1;
   localparam int SXY_T     = R2_T + 1;
   localparam int DD_T      = SXY_T + MUL_LAT + 1;
   localparam int E_T       = DD_T + 1;
   localparam int POLY_STEP = MUL_LAT + 1;
   localparam int DEN_T     = R2_T + 3 * POLY_STEP;
   localparam int IC_T      = DEN_T + RECIP_LAT;
   localparam int CELL_LAT  = IC_T + MUL_LAT;

   // distortion coefficients, already widened to Q.28
   typedef struct packed {
      word_type k1;
      word_type k2;
      word_type k3;
      word_type p1;
      word_type p2;
   } coef_type;

   typedef enum logic [2:0] {
      REG_PRINCIPAL = 3'd0,
      REG_INV_FX    = 3'd1,
      REG_INV_FY    = 3'd2,
      REG_K1        = 3'd3,
      REG_K2        = 3'd4,
      REG_K3        = 3'd5,
      REG_P1        = 3'd6,
      REG_P2        = 3'd7
   } reg_idx_type;

   function automatic sum_type sext_sum(input word_type w);
      sext_sum = {{(SUM_W-WORD_W){w[WORD_W-1]}}, w};
   endfunction

   function automatic sum_type dbl_sum(input word_type w);
      dbl_sum = {{(SUM_W-WORD_W-1){w[WORD_W-1]}}, w, 1'b0};
   endfunction

   function automatic word_type sat_word(input sum_type v);
      if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
         sat_word = v[WORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         sat_word = WORD_MIN;
      end else begin
         sat_word = WORD_MAX;
      end
   endfunction

   function automatic word_type widen_coef(input logic [31:0] c);
      widen_coef = {{(WORD_W-32-COEF_PAD){c[31]}}, c, {COEF_PAD{1'b0}}};
   endfunction

   function automatic out_type sat_out(input word_type w);
      if ((&w[WORD_W-1:OUT_W-1]) || !(|w[WORD_W-1:OUT_W-1])) begin
         sat_out = w[OUT_W-1:0];
      end else if (w[WORD_W-1]) begin
         sat_out = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_out = {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/lud_delay.sv
// Enabled shift-register delay line.
`timescale 1ns / 1ps
`default_nettype none

module lud_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_i,
   output logic [WIDTH-1:0] q_o
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q_o = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/lud_mul.sv
// Pipelined 48x48 signed multiply, shift right toward zero, magnitude saturation.
`timescale 1ns / 1ps
`default_nettype none

module lud_mul #(
   parameter int SHIFT = lud_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic              en,
   input  lud_pkg::word_type a_i,
   input  lud_pkg::word_type b_i,
   output lud_pkg::word_type p_o
);

   localparam int W    = lud_pkg::WORD_W;
   localparam int HALF = W / 2;
   localparam int PW   = 2 * W;

   logic                neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [W-1:0]        ua_ff, ub_ff, ua_in, ub_in;
   logic [W-1:0]        pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [PW-1:0]       lo_ff;
   logic [W:0]          mid_ff;
   logic [PW-1:0]       prod_ff;
   logic [PW-1:0]       shifted;
   logic [W-2:0]        mag;
   lud_pkg::word_type   p_ff, p_in;

   assign ua_in   = a_i[W-1] ? W'(-a_i) : W'(a_i);
   assign ub_in   = b_i[W-1] ? W'(-b_i) : W'(b_i);
   assign shifted = prod_ff >> SHIFT;
   assign mag     = (|shifted[PW-1:W-1]) ? {(W-1){1'b1}} : shifted[W-2:0];
   assign p_in    = neg4_ff ? -lud_pkg::word_type'({1'b0, mag})
                            :  lud_pkg::word_type'({1'b0, mag});

   always_ff @(posedge clock) begin
      if (en) begin
         // magnitudes
         neg1_ff <= a_i[W-1] ^ b_i[W-1];
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         // partial products
         neg2_ff <= neg1_ff;
         pp00_ff <= ua_ff[HALF-1:0] * ub_ff[HALF-1:0];
         pp01_ff <= ua_ff[HALF-1:0] * ub_ff[W-1:HALF];
         pp10_ff <= ua_ff[W-1:HALF] * ub_ff[HALF-1:0];
         pp11_ff <= ua_ff[W-1:HALF] * ub_ff[W-1:HALF];
         // outer products do not overlap
         neg3_ff <= neg2_ff;
         lo_ff   <= {pp11_ff, pp00_ff};
         mid_ff  <= {1'b0, pp01_ff} + {1'b0, pp10_ff};
         neg4_ff <= neg3_ff;
         prod_ff <= lo_ff + {{(PW-W-1-HALF){1'b0}}, mid_ff, {HALF{1'b0}}};
         p_ff    <= p_in;
      end
   end

   assign p_o = p_ff;

endmodule

`default_nettype wire

// File: rtl/lud_recip.sv
// Pipelined restoring reciprocal 2^56/den, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lud_recip (
   input  logic              clock,
   input  logic              en,
   input  lud_pkg::word_type den_i,
   output lud_pkg::word_type ic_o
);

   localparam int W  = lud_pkg::WORD_W;
   localparam int QB = lud_pkg::Q_BITS;

   logic [W-1:0]  mag_ff   [QB+1];
   logic [W-1:0]  rem_ff   [QB+1];
   logic [QB-1:0] q_ff     [QB+1];
   logic          neg_ff   [QB+1];
   logic          small_ff [QB+1];
   logic [W-1:0]  rem_in   [QB];
   logic [QB-1:0] q_in     [QB];
   logic [W-1:0]  mag0_in;
   lud_pkg::word_type ic_ff, ic_in;

   assign mag0_in = den_i[W-1] ? W'(-den_i) : W'(den_i);

   always_comb begin
      for (int s = 0; s < QB; s++) begin
         logic [W:0] trial;
         logic       ge;
         trial     = {rem_ff[s], 1'b0};
         ge        = trial >= {1'b0, mag_ff[s]};
         rem_in[s] = ge ? W'(trial - {1'b0, mag_ff[s]}) : trial[W-1:0];
         q_in[s]   = {q_ff[s][QB-2:0], ge};
      end
   end

   // small magnitudes (zero included) overflow the quotient range
   always_comb begin
      if (small_ff[QB]) begin
         ic_in = neg_ff[QB] ? -lud_pkg::WORD_MAX : lud_pkg::WORD_MAX;
      end else if (neg_ff[QB]) begin
         ic_in = -lud_pkg::word_type'({1'b0, q_ff[QB]});
      end else begin
         ic_in = lud_pkg::word_type'({1'b0, q_ff[QB]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff[0]   <= mag0_in;
         neg_ff[0]   <= den_i[W-1];
         small_ff[0] <= mag0_in <= lud_pkg::REM_INIT;
         rem_ff[0]   <= lud_pkg::REM_INIT;
         q_ff[0]     <= '0;
         for (int s = 0; s < QB; s++) begin
            mag_ff[s+1]   <= mag_ff[s];
            neg_ff[s+1]   <= neg_ff[s];
            small_ff[s+1] <= small_ff[s];
            rem_ff[s+1]   <= rem_in[s];
            q_ff[s+1]     <= q_in[s];
         end
         ic_ff <= ic_in;
      end
   end

   assign ic_o = ic_ff;

endmodule

`default_nettype wire

// File: rtl/lud_cell.sv
// One undistortion iteration as a fixed-latency pipeline cell.
`timescale 1ns / 1ps
`default_nettype none

module lud_cell (
   input  logic              clock,
   input  logic              en,
   input  lud_pkg::coef_type coef_i,
   input  lud_pkg::word_type x_i,
   input  lud_pkg::word_type y_i,
   input  lud_pkg::word_type x0_i,
   input  lud_pkg::word_type y0_i,
   output lud_pkg::word_type x_o,
   output lud_pkg::word_type y_o,
   output lud_pkg::word_type x0_o,
   output lud_pkg::word_type y0_o
);

   localparam int W = lud_pkg::WORD_W;

   lud_pkg::word_type xx, yy, xy;
   lud_pkg::word_type r2_ff, xx_ff, yy_ff, xy_ff;
   lud_pkg::word_type sx_ff, sy_ff, xyb_ff;
   lud_pkg::word_type r2_d1, r2_d2;
   lud_pkg::word_type m1, m2, m3;
   lud_pkg::word_type pa_ff, pb_ff, den_ff, ic;
   lud_pkg::word_type t1, t2, t3, t4;
   lud_pkg::word_type ddx_ff, ddy_ff;
   lud_pkg::word_type x0_d, y0_d, ex_ff, ey_ff, ex_d, ey_d;

   lud_mul u_mxx (.clock, .en, .a_i(x_i), .b_i(x_i), .p_o(xx));
   lud_mul u_myy (.clock, .en, .a_i(y_i), .b_i(y_i), .p_o(yy));
   lud_mul u_mxy (.clock, .en, .a_i(x_i), .b_i(y_i), .p_o(xy));

   // radial polynomial in Horner form
   lud_mul u_m1 (.clock, .en, .a_i(coef_i.k3), .b_i(r2_ff), .p_o(m1));
   lud_mul u_m2 (.clock, .en, .a_i(pa_ff),     .b_i(r2_d1), .p_o(m2));
   lud_mul u_m3 (.clock, .en, .a_i(pb_ff),     .b_i(r2_d2), .p_o(m3));

   lud_delay #(.WIDTH(W), .DEPTH(lud_pkg::POLY_STEP)) u_dr2a (
      .clock, .en, .d_i(r2_ff), .q_o(r2_d1));
   lud_delay #(.WIDTH(W), .DEPTH(lud_pkg::POLY_STEP)) u_dr2b (
      .clock, .en, .d_i(r2_d1), .q_o(r2_d2));

   lud_recip u_recip (.clock, .en, .den_i(den_ff), .ic_o(ic));

   // tangential terms
   lud_mul u_t1 (.clock, .en, .a_i(coef_i.p1), .b_i(xyb_ff), .p_o(t1));
   lud_mul u_t2 (.clock, .en, .a_i(coef_i.p2), .b_i(sx_ff),  .p_o(t2));
   lud_mul u_t3 (.clock, .en, .a_i(coef_i.p1), .b_i(sy_ff),  .p_o(t3));
   lud_mul u_t4 (.clock, .en, .a_i(coef_i.p2), .b_i(xyb_ff), .p_o(t4));

   lud_delay #(.WIDTH(W), .DEPTH(lud_pkg::DD_T)) u_dx0 (
      .clock, .en, .d_i(x0_i), .q_o(x0_d));
   lud_delay #(.WIDTH(W), .DEPTH(lud_pkg::DD_T)) u_dy0 (
      .clock, .en, .d_i(y0_i), .q_o(y0_d));

   lud_delay #(.WIDTH(W), .DEPTH(lud_pkg::IC_T - lud_pkg::E_T)) u_dex (
      .clock, .en, .d_i(ex_ff), .q_o(ex_d));
   lud_delay #(.WIDTH(W), .DEPTH(lud_pkg::IC_T - lud_pkg::E_T)) u_dey (
      .clock, .en, .d_i(ey_ff), .q_o(ey_d));

   lud_mul u_mx (.clock, .en, .a_i(ex_d), .b_i(ic), .p_o(x_o));
   lud_mul u_my (.clock, .en, .a_i(ey_d), .b_i(ic), .p_o(y_o));

   // x0/y0 travel along to the next cell
   lud_delay #(.WIDTH(W), .DEPTH(lud_pkg::CELL_LAT - lud_pkg::DD_T)) u_ox0 (
      .clock, .en, .d_i(x0_d), .q_o(x0_o));
   lud_delay #(.WIDTH(W), .DEPTH(lud_pkg::CELL_LAT - lud_pkg::DD_T)) u_oy0 (
      .clock, .en, .d_i(y0_d), .q_o(y0_o));

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff  <= lud_pkg::sat_word(lud_pkg::sext_sum(xx) + lud_pkg::sext_sum(yy));
         xx_ff  <= xx;
         yy_ff  <= yy;
         xy_ff  <= xy;
         sx_ff  <= lud_pkg::sat_word(lud_pkg::sext_sum(r2_ff) + lud_pkg::dbl_sum(xx_ff));
         sy_ff  <= lud_pkg::sat_word(lud_pkg::sext_sum(r2_ff) + lud_pkg::dbl_sum(yy_ff));
         xyb_ff <= xy_ff;
         pa_ff  <= lud_pkg::sat_word(lud_pkg::sext_sum(m1) + lud_pkg::sext_sum(coef_i.k2));
         pb_ff  <= lud_pkg::sat_word(lud_pkg::sext_sum(m2) + lud_pkg::sext_sum(coef_i.k1));
         den_ff <= lud_pkg::sat_word(lud_pkg::sext_sum(m3)
                                     + lud_pkg::sext_sum(lud_pkg::ONE_Q28));
         ddx_ff <= lud_pkg::sat_word(lud_pkg::dbl_sum(t1) + lud_pkg::sext_sum(t2));
         ddy_ff <= lud_pkg::sat_word(lud_pkg::sext_sum(t3) + lud_pkg::dbl_sum(t4));
         ex_ff  <= lud_pkg::sat_word(lud_pkg::sext_sum(x0_d) - lud_pkg::sext_sum(ddx_ff));
         ey_ff  <= lud_pkg::sat_word(lud_pkg::sext_sum(y0_d) - lud_pkg::sext_sum(ddy_ff));
      end
   end

endmodule

`default_nettype wire

// File: rtl/lens_undistort_points_unit.sv
// Top level: iterative Brown-Conrady point undistortion pipeline.
//
//   channel | direction | handshake                      | word
//   req     | in        | req_valid / req_stall          | req_pixel_x, req_pixel_y (Q16.16)
//   rsp     | out       | rsp_valid / rsp_stall          | rsp_norm_x, rsp_norm_y (Q4.28)
//   csr     | in/out    | psel penable pwrite pready     | paddr, pwdata, prdata (64 bit)
//
// One word enters per cycle while the pipeline is not held. Each iteration cell's
// depth is set by its 49-stage reciprocal and five chained 5-stage multipliers.
// Reset is synchronous and clears the configuration registers, the valid chain and rsp_valid.
// The whole pipeline holds only when its last stage has a word and the output
// register is full and stalled; otherwise it advances every cycle.
`timescale 1ns / 1ps
`default_nettype none

module lens_undistort_points_unit #(
   parameter int ITERATIONS = lud_pkg::ITERATIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_x,
   input  logic [31:0] req_pixel_y,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_norm_x,
   output logic signed [31:0] rsp_norm_y,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   localparam int LAT = lud_pkg::FRONT_LAT + ITERATIONS * lud_pkg::CELL_LAT;

   // configuration registers
   logic [63:0] pp_ff;
   logic [31:0] ifx_ff, ify_ff, k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;
   logic        wr_en;
   lud_pkg::reg_idx_type reg_idx;

   // pipeline control
   logic           adv, accept;
   logic [LAT-1:0] vld_ff, vld_in;
   logic           rsp_valid_ff, rsp_valid_in, out_free;
   lud_pkg::out_type nx_ff, ny_ff;

   // datapath
   lud_pkg::word_type dx_ff, dy_ff, dx_in, dy_in, fx, fy, x0, y0;
   lud_pkg::coef_type coef;
   lud_pkg::word_type x_c  [ITERATIONS+1];
   lud_pkg::word_type y_c  [ITERATIONS+1];
   lud_pkg::word_type x0_c [ITERATIONS+1];
   lud_pkg::word_type y0_c [ITERATIONS+1];

   //------------------------------------------------------------------
   // register port
   //------------------------------------------------------------------
   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = lud_pkg::reg_idx_type'(paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff  <= '0;
         ifx_ff <= '0;
         ify_ff <= '0;
         k1_ff  <= '0;
         k2_ff  <= '0;
         k3_ff  <= '0;
         p1_ff  <= '0;
         p2_ff  <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            lud_pkg::REG_PRINCIPAL: pp_ff  <= pwdata;
            lud_pkg::REG_INV_FX:    ifx_ff <= pwdata[31:0];
            lud_pkg::REG_INV_FY:    ify_ff <= pwdata[31:0];
            lud_pkg::REG_K1:        k1_ff  <= pwdata[31:0];
            lud_pkg::REG_K2:        k2_ff  <= pwdata[31:0];
            lud_pkg::REG_K3:        k3_ff  <= pwdata[31:0];
            lud_pkg::REG_P1:        p1_ff  <= pwdata[31:0];
            lud_pkg::REG_P2:        p2_ff  <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         lud_pkg::REG_PRINCIPAL: prdata = pp_ff;
         lud_pkg::REG_INV_FX:    prdata = {32'b0, ifx_ff};
         lud_pkg::REG_INV_FY:    prdata = {32'b0, ify_ff};
         lud_pkg::REG_K1:        prdata = {32'b0, k1_ff};
         lud_pkg::REG_K2:        prdata = {32'b0, k2_ff};
         lud_pkg::REG_K3:        prdata = {32'b0, k3_ff};
         lud_pkg::REG_P1:        prdata = {32'b0, p1_ff};
         lud_pkg::REG_P2:        prdata = {32'b0, p2_ff};
         default:                prdata = '0;
      endcase
   end

   // Q8.24 -> Q.28, fed live; user must change registers only while idle (unenforced)
   assign coef.k1 = lud_pkg::widen_coef(k1_ff);
   assign coef.k2 = lud_pkg::widen_coef(k2_ff);
   assign coef.k3 = lud_pkg::widen_coef(k3_ff);
   assign coef.p1 = lud_pkg::widen_coef(p1_ff);
   assign coef.p2 = lud_pkg::widen_coef(p2_ff);

   //------------------------------------------------------------------
   // flow control
   //------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign adv          = !vld_ff[LAT-1] || out_free;
   assign req_stall    = !adv;
   assign accept       = req_valid && adv;
   assign vld_in       = {vld_ff[LAT-2:0], accept};
   assign rsp_valid_in = out_free ? vld_ff[LAT-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   //------------------------------------------------------------------
   // front end: offset from principal point, scale by 1/f
   //------------------------------------------------------------------
   assign dx_in = lud_pkg::word_type'({16'b0, req_pixel_x})
                - lud_pkg::word_type'({16'b0, pp_ff[31:0]});
   assign dy_in = lud_pkg::word_type'({16'b0, req_pixel_y})
                - lud_pkg::word_type'({16'b0, pp_ff[63:32]});
   assign fx    = lud_pkg::word_type'({16'b0, ifx_ff});
   assign fy    = lud_pkg::word_type'({16'b0, ify_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   lud_mul #(.SHIFT(lud_pkg::FRONT_SHIFT)) u_fx (
      .clock, .en(adv), .a_i(dx_ff), .b_i(fx), .p_o(x0));
   lud_mul #(.SHIFT(lud_pkg::FRONT_SHIFT)) u_fy (
      .clock, .en(adv), .a_i(dy_ff), .b_i(fy), .p_o(y0));

   //------------------------------------------------------------------
   // chain of iteration cells
   //------------------------------------------------------------------
   assign x_c[0]  = x0;
   assign y_c[0]  = y0;
   assign x0_c[0] = x0;
   assign y0_c[0] = y0;

   for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
      lud_cell u_cell (
         .clock,
         .en    (adv),
         .coef_i(coef),
         .x_i   (x_c[g]),
         .y_i   (y_c[g]),
         .x0_i  (x0_c[g]),
         .y0_i  (y0_c[g]),
         .x_o   (x_c[g+1]),
         .y_o   (y_c[g+1]),
         .x0_o  (x0_c[g+1]),
         .y0_o  (y0_c[g+1])
      );
   end

   //------------------------------------------------------------------
   // output register, saturate to Q4.28
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (out_free) begin
         nx_ff <= lud_pkg::sat_out(x_c[ITERATIONS]);
         ny_ff <= lud_pkg::sat_out(y_c[ITERATIONS]);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_norm_x = nx_ff;
   assign rsp_norm_y = ny_ff;

`ifndef NO_ASSERTIONS
   // a finished word moves into a free output register
   a_drain: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-1] && out_free |=> rsp_valid_ff)
      else $error("finished word not delivered to output register");

   // input is held back only when the last stage and output are both full
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> vld_ff[LAT-1] && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a full pipeline end");

   // a frozen pipeline keeps its valid chain
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid chain moved while pipeline frozen");
`endif

endmodule

`default_nettype wire

// File: tb/lens_undistort_points_unit_tb.sv
// Testbench for the lens point undistortion unit: directed and random pixels, scoreboard check.
`timescale 1ns / 1ps

module lens_undistort_points_unit_tb;

   localparam int NITER      = 5;
   localparam int LAT        = 397;      // pipeline depth incl. output register
   localparam int WATCH_MAX  = 20000;    // idle cycles before the watchdog fires
   localparam longint WMAXL  = 64'sd140737488355327;
   localparam longint WMINL  = -64'sd140737488355328;
   localparam longint ONEQ   = 64'sd268435456;

   // -------------------------------------------------------------------------
   // Undistortion predictor: bit-exact fixed-point math, own copy of the CSRs
   // -------------------------------------------------------------------------
   class undistort_scoreboard;
      logic [63:0] pp;
      logic [31:0] ifx, ify;
      logic signed [31:0] ck1, ck2, ck3, cp1, cp2;
      logic signed [31:0] want_x[$], want_y[$];
      int errors, checked;

      function new();
         pp = 0; ifx = 0; ify = 0;
         ck1 = 0; ck2 = 0; ck3 = 0; cp1 = 0; cp2 = 0;
         errors = 0; checked = 0;
      endfunction

      function void write_reg(lud_pkg::reg_idx_type idx, logic [63:0] v);
         case (idx)
            lud_pkg::REG_PRINCIPAL: pp = v;
            lud_pkg::REG_INV_FX:    ifx = v[31:0];
            lud_pkg::REG_INV_FY:    ify = v[31:0];
            lud_pkg::REG_K1:        ck1 = v[31:0];
            lud_pkg::REG_K2:        ck2 = v[31:0];
            lud_pkg::REG_K3:        ck3 = v[31:0];
            lud_pkg::REG_P1:        cp1 = v[31:0];
            lud_pkg::REG_P2:        cp2 = v[31:0];
            default: ;
         endcase
      endfunction

      function longint clampw(logic signed [127:0] v);
         if (v > WMAXL) return WMAXL;
         if (v < WMINL) return WMINL;
         return longint'(v);
      endfunction

      // product shifted toward zero, magnitude capped at 2^47-1
      function longint mul_shift(longint a, longint b, int sh);
         logic signed [127:0] p;
         logic [127:0] m;
         p = 128'(signed'(a)) * 128'(signed'(b));
         m = p < 0 ? -p : p;
         m = m >> sh;
         if (m > 128'(WMAXL)) m = 128'(WMAXL);
         return p < 0 ? -longint'(m) : longint'(m);
      endfunction

      function longint recip(longint den);
         logic [63:0] mag, q;
         if (den == 0) return WMAXL;
         mag = den < 0 ? -den : den;
         q = (64'd1 << 56) / mag;
         if (q > 64'(WMAXL)) q = 64'(WMAXL);
         return den < 0 ? -longint'(q) : longint'(q);
      endfunction

      function logic signed [31:0] to_q428(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function void note_pixel(logic [31:0] px, logic [31:0] py);
         longint x0, y0, x, y, k1, k2, k3, p1, p2;
         longint xx, yy, xy, r2, poly, ic, ddx, ddy;
         x0 = mul_shift(longint'({32'd0, px}) - longint'({32'd0, pp[31:0]}),
                        longint'({32'd0, ifx}), 20);
         y0 = mul_shift(longint'({32'd0, py}) - longint'({32'd0, pp[63:32]}),
                        longint'({32'd0, ify}), 20);
         k1 = longint'(ck1) * 16; k2 = longint'(ck2) * 16; k3 = longint'(ck3) * 16;
         p1 = longint'(cp1) * 16; p2 = longint'(cp2) * 16;
         x = x0; y = y0;
         for (int i = 0; i < NITER; i++) begin
            xx = mul_shift(x, x, 28);
            yy = mul_shift(y, y, 28);
            xy = mul_shift(x, y, 28);
            r2 = clampw(128'(xx) + yy);
            poly = clampw(128'(mul_shift(k3, r2, 28)) + k2);
            poly = clampw(128'(mul_shift(poly, r2, 28)) + k1);
            poly = clampw(128'(mul_shift(poly, r2, 28)) + ONEQ);
            ic = recip(poly);
            ddx = clampw(128'(mul_shift(p1, xy, 28)) * 2
                         + mul_shift(p2, clampw(128'(r2) + 2 * 128'(xx)), 28));
            ddy = clampw(128'(mul_shift(p1, clampw(128'(r2) + 2 * 128'(yy)), 28))
                         + 2 * 128'(mul_shift(p2, xy, 28)));
            x = mul_shift(clampw(128'(x0) - ddx), ic, 28);
            y = mul_shift(clampw(128'(y0) - ddy), ic, 28);
         end
         want_x.push_back(to_q428(x));
         want_y.push_back(to_q428(y));
      endfunction

      function void check_point(logic signed [31:0] nx, logic signed [31:0] ny);
         logic signed [31:0] ex, ey;
         if (want_x.size() == 0) begin
            $error("result word with nothing expected: x=%0d y=%0d", nx, ny);
            errors++;
            return;
         end
         ex = want_x.pop_front();
         ey = want_y.pop_front();
         checked++;
         if (nx !== ex) begin
            $error("norm_x expected %0d actual %0d", ex, nx);
            errors++;
         end
         if (ny !== ey) begin
            $error("norm_y expected %0d actual %0d", ey, ny);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and signals
   // -------------------------------------------------------------------------
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_pixel_x = 0, req_pixel_y = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic signed [31:0] rsp_norm_x, rsp_norm_y;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [5:0]  paddr = 0;
   logic [63:0] pwdata = 0;
   logic [63:0] prdata;
   logic        pready;

   lens_undistort_points_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   undistort_scoreboard sb = new();
   bit quiet_tail = 0;      // last part of the run: no random gaps or output stalls
   int idle_cycles = 0;
   int sent = 0;

   // Result side: random stall bursts, checks each accepted word.
   initial begin : rsp_side
      int n;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_point(rsp_norm_x, rsp_norm_y);
         if (quiet_tail) begin
            rsp_stall <= 0;
         end else if (rsp_stall) begin
            if (n > 0) n--;
            else rsp_stall <= 0;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_stall <= 1;
            n = $urandom_range(0, 13);     // random burst length
         end
      end
   end

   // Watchdog: counts cycles where neither channel moves a word.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
         $display("lens_undistort_points_unit_tb NOT OK");
         $finish;
      end
   end

   // Register write: setup, then access, then idle; pready is always high.
   task automatic csr_write(lud_pkg::reg_idx_type idx, logic [63:0] v);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= 6'(idx) << 3;   // principal point is 64 bits, so 8-byte stride
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.write_reg(idx, v);
      @(posedge clock);
   endtask

   // Send one word; holds valid across back-to-back items, drops it only in gaps.
   task automatic send_pixel(logic [31:0] px, logic [31:0] py);
      int gap;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(px, py);
      sent++;
   endtask

   // Drain: wait until nothing is pending, plus the pipeline depth.
   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (sb.want_x.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pix();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hffffffff;
         2: return $urandom();
         default: return $urandom_range(0, 32'h07ff_ffff);  // within ~2k px
      endcase
   endfunction

   // Coefficient: mostly realistic small values, sometimes extremes.
   function automatic logic [31:0] rand_coef(int mode);
      case (mode)
         0: return 32'h0;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return $urandom();
         default: return 32'(signed'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      endcase
   endfunction

   // Random configuration phase; mode picks extremes vs. realistic lenses.
   task automatic program_lens(int mode);
      logic [63:0] pp;
      pp = {$urandom_range(0, 32'h07ff_ffff), $urandom_range(0, 32'h07ff_ffff)};
      if (mode == 1) pp = 64'hffffffff_ffffffff;
      if (mode == 3) pp = {$urandom(), $urandom()};
      csr_write(lud_pkg::REG_PRINCIPAL, pp);
      csr_write(lud_pkg::REG_INV_FX,
                mode == 1 ? 32'hffffffff : $urandom_range(1, 32'h0100_0000));
      csr_write(lud_pkg::REG_INV_FY,
                mode == 1 ? 32'hffffffff : $urandom_range(1, 32'h0100_0000));
      csr_write(lud_pkg::REG_K1,
                rand_coef(mode == 1 ? $urandom_range(1, 2) : mode == 3 ? 3 : 4));
      csr_write(lud_pkg::REG_K2,
                rand_coef(mode == 1 ? $urandom_range(1, 2) : mode == 3 ? 3 : 4));
      csr_write(lud_pkg::REG_K3,
                rand_coef(mode == 1 ? $urandom_range(1, 2) : mode == 3 ? 3 : 4));
      csr_write(lud_pkg::REG_P1,
                rand_coef(mode == 1 ? $urandom_range(1, 2) : mode == 3 ? 3 : 4));
      csr_write(lud_pkg::REG_P2,
                rand_coef(mode == 1 ? $urandom_range(1, 2) : mode == 3 ? 3 : 4));
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed, reset config: all-zero setup gives zero output.
      send_pixel(32'h0, 32'h0);
      send_pixel(32'hffffffff, 32'hffffffff);
      settle();

      // Plain normalization, zero coefficients, large reciprocal.
      csr_write(lud_pkg::REG_PRINCIPAL, {32'h0200_0000, 32'h0300_0000});
      csr_write(lud_pkg::REG_INV_FX, 32'h0010_0000);
      csr_write(lud_pkg::REG_INV_FY, 32'hffffffff);
      send_pixel(32'h0, 32'h0);
      send_pixel(32'hffffffff, 32'hffffffff);
      send_pixel(32'h0300_0000, 32'h0200_0000);
      settle();

      // k1 = -1: denominator crosses zero and goes negative near r2 = 1.
      csr_write(lud_pkg::REG_INV_FX, 32'h0100_0000);
      csr_write(lud_pkg::REG_INV_FY, 32'h0100_0000);
      csr_write(lud_pkg::REG_K1, 32'hff00_0000);
      send_pixel(32'h0400_0000, 32'h0200_0000);   // x0 = 1: den exactly zero
      send_pixel(32'h0500_0000, 32'h0200_0000);
      send_pixel(32'h0310_0000, 32'h0280_0000);
      settle();

      // Extreme coefficients: saturation everywhere.
      csr_write(lud_pkg::REG_K1, 32'h7fffffff);
      csr_write(lud_pkg::REG_K2, 32'h80000000);
      csr_write(lud_pkg::REG_K3, 32'h7fffffff);
      csr_write(lud_pkg::REG_P1, 32'h80000000);
      csr_write(lud_pkg::REG_P2, 32'h7fffffff);
      csr_write(lud_pkg::REG_INV_FX, 32'hffffffff);
      send_pixel(32'h0, 32'hffffffff);
      send_pixel(32'hffffffff, 32'h0);
      send_pixel(32'h0300_0001, 32'h0200_0001);
      send_pixel(32'h8000_0000, 32'h8000_0000);
      settle();

      // Random phases with fresh lens settings, ~1800 items.
      for (int ph = 0; ph < 18; ph++) begin
         program_lens(ph < 4 ? ph : $urandom_range(0, 4) == 0 ? 3 : 2);
         if (ph == 15) quiet_tail = 1;
         for (int i = 0; i < 100; i++) send_pixel(rand_pix(), rand_pix());
         if (ph < 17) settle();
      end
      settle();

      $display("covered %0d pixels over 22 lens settings; %0d results checked",
               sent, sb.checked);
      $display("including zero/negative denominators and saturated outputs");
      if (sb.errors == 0 && sb.want_x.size() == 0)
         $display("lens_undistort_points_unit_tb OK");
      else
         $display("lens_undistort_points_unit_tb NOT OK");
      $finish;
   end

endmodule

// File: files.f
rtl/lud_pkg.sv
rtl/lud_delay.sv
rtl/lud_mul.sv
rtl/lud_recip.sv
rtl/lud_cell.sv
rtl/lens_undistort_points_unit.sv
tb/lens_undistort_points_unit_tb.sv
